// ===== hdl/cfsp_pkg.sv =====
// Shared types and constants for the class file structure parser.
// No dependencies.
`timescale 1ns / 1ps
package cfsp_pkg;
    typedef enum logic [4:0] {
        K_MAGIC = 5'd0, K_MINOR = 5'd1, K_MAJOR = 5'd2, K_POOL_COUNT = 5'd3,
        K_POOL_TAG = 5'd4, K_POOL_OPERAND = 5'd5, K_UTF8 = 5'd6, K_ACCESS = 5'd7,
        K_THIS = 5'd8, K_SUPER = 5'd9, K_IFACE_COUNT = 5'd10, K_IFACE = 5'd11,
        K_FIELDS_COUNT = 5'd12, K_MFLAGS = 5'd13, K_MNAME = 5'd14, K_MDESC = 5'd15,
        K_MATTRC = 5'd16, K_ANAME = 5'd17, K_ALEN = 5'd18, K_AINFO = 5'd19,
        K_METHODS_COUNT = 5'd20, K_TRAILING = 5'd21, K_HALTED = 5'd22
    } kind_t;

    // parser phase, one-hot
    typedef enum logic [22:0] {
        S_MAGIC         = 23'h000001, S_MINOR         = 23'h000002,
        S_MAJOR         = 23'h000004, S_POOL_COUNT    = 23'h000008,
        S_POOL_TAG      = 23'h000010, S_POOL_OPERAND  = 23'h000020,
        S_UTF8          = 23'h000040, S_ACCESS        = 23'h000080,
        S_THIS          = 23'h000100, S_SUPER         = 23'h000200,
        S_IFACE_COUNT   = 23'h000400, S_IFACE         = 23'h000800,
        S_FIELDS_COUNT  = 23'h001000, S_MFLAGS        = 23'h002000,
        S_MNAME         = 23'h004000, S_MDESC         = 23'h008000,
        S_MATTRC        = 23'h010000, S_ANAME         = 23'h020000,
        S_ALEN          = 23'h040000, S_AINFO         = 23'h080000,
        S_METHODS_COUNT = 23'h100000, S_TRAILING      = 23'h200000,
        S_HALTED        = 23'h400000
    } state_t;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_MAGIC = 2'd1;
    localparam logic [1:0] ERR_TAG   = 2'd2;

    localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;
    localparam int unsigned STATIC_BIT_POS = 3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       starts_file;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  element_kind;
        logic        in_method;
        logic [15:0] entry_index;
        logic [15:0] attribute_index;
        logic [1:0]  operand_number;
        logic [63:0] value;
        logic        value_complete;
        logic        field_is_static;
        logic [15:0] field_slot;
        logic [1:0]  error_code;
        logic        parse_done;
    } out_word_t;

    function automatic logic tag_known(input logic [7:0] t);
        return (t == 8'd1) || (t >= 8'd3 && t <= 8'd12) || (t == 8'd15) ||
               (t == 8'd16) || (t == 8'd18);
    endfunction

    function automatic logic [1:0] tag_operands(input logic [7:0] t);
        return (t == 8'd9 || t == 8'd10 || t == 8'd11 || t == 8'd12 ||
                t == 8'd15 || t == 8'd18) ? 2'd2 : 2'd1;
    endfunction

    function automatic logic [3:0] operand_size(input logic [7:0] t, input logic [1:0] op);
        logic [3:0] sz;
        sz = 4'd2;
        if (t == 8'd15)
            sz = (op == 2'd1) ? 4'd1 : 4'd2;
        else if (t == 8'd3 || t == 8'd4)
            sz = 4'd4;
        else if (t == 8'd5 || t == 8'd6)
            sz = 4'd8;
        return sz;
    endfunction
endpackage

// ===== hdl/cfsp_stream_if.sv =====
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on cfsp_pkg only through the payload type supplied.
`timescale 1ns / 1ps
interface cfsp_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/cfsp_core.sv =====
// Parser state machine: one byte in, one result word out, per step.
// Depends on cfsp_pkg.
`timescale 1ns / 1ps
module cfsp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  cfsp_pkg::in_word_t  din,
    output cfsp_pkg::out_word_t dout
);
    import cfsp_pkg::*;

    state_t      phase_reg, phase_next;
    logic [2:0]  bif_reg, bif_next;
    logic [63:0] acc_reg, acc_next;
    logic [15:0] pidx_reg, pidx_next, pcnt_reg, pcnt_next;
    logic [7:0]  tag_reg, tag_next;
    logic [1:0]  opc_reg, opc_next;
    logic [15:0] iidx_reg, iidx_next, icnt_reg, icnt_next;
    logic [15:0] aidx_reg, aidx_next, acnt_reg, acnt_next;
    logic [31:0] brem_reg, brem_next;
    logic [15:0] sslot_reg, sslot_next, islot_reg, islot_next;
    logic        msec_reg, msec_next;
    logic [1:0]  err_reg, err_next;

    // effective state after an optional restart
    state_t      ph;
    logic [2:0]  bif;
    logic [63:0] acc;
    logic [15:0] pidx, pcnt, iidx, icnt, aidx, acnt, sslot, islot;
    logic [7:0]  tag;
    logic [1:0]  opc, err;
    logic [31:0] brem;
    logic        msec;

    logic [7:0]  b;
    logic [3:0]  fsz;
    logic        fin;
    logic [63:0] shifted;
    logic [16:0] pool_n;
    logic [15:0] inext, anext;
    logic [31:0] brem_dec;

    function automatic kind_t state_kind(input state_t s);
        kind_t k;
        k = K_HALTED;
        case (s)
            S_MAGIC:         k = K_MAGIC;
            S_MINOR:         k = K_MINOR;
            S_MAJOR:         k = K_MAJOR;
            S_POOL_COUNT:    k = K_POOL_COUNT;
            S_POOL_TAG:      k = K_POOL_TAG;
            S_POOL_OPERAND:  k = K_POOL_OPERAND;
            S_UTF8:          k = K_UTF8;
            S_ACCESS:        k = K_ACCESS;
            S_THIS:          k = K_THIS;
            S_SUPER:         k = K_SUPER;
            S_IFACE_COUNT:   k = K_IFACE_COUNT;
            S_IFACE:         k = K_IFACE;
            S_FIELDS_COUNT:  k = K_FIELDS_COUNT;
            S_MFLAGS:        k = K_MFLAGS;
            S_MNAME:         k = K_MNAME;
            S_MDESC:         k = K_MDESC;
            S_MATTRC:        k = K_MATTRC;
            S_ANAME:         k = K_ANAME;
            S_ALEN:          k = K_ALEN;
            S_AINFO:         k = K_AINFO;
            S_METHODS_COUNT: k = K_METHODS_COUNT;
            S_TRAILING:      k = K_TRAILING;
            default:         k = K_HALTED;
        endcase
        return k;
    endfunction

    always_comb
    begin
        b = din.byte_value;
        if (din.starts_file)
        begin
            ph = S_MAGIC; bif = '0; acc = '0; pidx = 16'd1; pcnt = '0; tag = '0;
            opc = '0; iidx = '0; icnt = '0; aidx = '0; acnt = '0; brem = '0;
            sslot = '0; islot = '0; msec = 1'b0; err = ERR_NONE;
        end
        else
        begin
            ph = phase_reg; bif = bif_reg; acc = acc_reg; pidx = pidx_reg;
            pcnt = pcnt_reg; tag = tag_reg; opc = opc_reg; iidx = iidx_reg;
            icnt = icnt_reg; aidx = aidx_reg; acnt = acnt_reg; brem = brem_reg;
            sslot = sslot_reg; islot = islot_reg; msec = msec_reg; err = err_reg;
        end

        phase_next = ph; bif_next = bif; acc_next = acc; pidx_next = pidx;
        pcnt_next = pcnt; tag_next = tag; opc_next = opc; iidx_next = iidx;
        icnt_next = icnt; aidx_next = aidx; acnt_next = acnt; brem_next = brem;
        sslot_next = sslot; islot_next = islot; msec_next = msec; err_next = err;

        dout = '0;
        dout.element_kind = state_kind(ph);

        case (ph)
            S_MAGIC:                          fsz = 4'd4;
            S_ALEN:                           fsz = 4'd4;
            S_POOL_TAG:                       fsz = 4'd1;
            S_POOL_OPERAND:                   fsz = operand_size(tag, opc);
            default:                          fsz = 4'd2;
        endcase
        shifted = (bif == 3'd0) ? {56'd0, b} : {acc[55:0], b};
        fin = ({1'b0, bif} + 4'd1) >= fsz;
        pool_n = {1'b0, pidx} + ((tag == 8'd5 || tag == 8'd6) ? 17'd2 : 17'd1);
        inext = iidx + 16'd1;
        anext = aidx + 16'd1;
        brem_dec = brem - 32'd1;

        // multi-byte field phases share the accumulator
        if (ph != S_HALTED && ph != S_TRAILING && ph != S_UTF8 && ph != S_AINFO)
        begin
            acc_next = shifted;
            bif_next = fin ? 3'd0 : bif + 3'd1;
            dout.value_complete = fin;
            if (fin)
                dout.value = shifted;
        end

        case (ph)
            S_HALTED: ;
            S_TRAILING: dout.value = {56'd0, b};
            S_MAGIC:
                if (fin)
                begin
                    if (shifted[31:0] != MAGIC_WORD)
                    begin
                        err_next = ERR_MAGIC;
                        phase_next = S_HALTED;
                    end
                    else
                        phase_next = S_MINOR;
                end
            S_MINOR:
                if (fin) phase_next = S_MAJOR;
            S_ACCESS:
                if (fin) phase_next = S_THIS;
            S_THIS:
                if (fin) phase_next = S_SUPER;
            S_SUPER:
                if (fin) phase_next = S_IFACE_COUNT;
            S_MAJOR:
                if (fin) phase_next = S_POOL_COUNT;
            S_POOL_COUNT:
                if (fin)
                begin
                    pcnt_next = shifted[15:0];
                    pidx_next = 16'd1;
                    phase_next = (shifted[15:0] <= 16'd1) ? S_ACCESS : S_POOL_TAG;
                end
            S_POOL_TAG:
            begin
                dout.entry_index = pidx;
                tag_next = b;
                if (!tag_known(b))
                begin
                    err_next = ERR_TAG;
                    phase_next = S_HALTED;
                end
                else
                begin
                    opc_next = 2'd1;
                    phase_next = S_POOL_OPERAND;
                end
            end
            S_POOL_OPERAND:
            begin
                dout.entry_index = pidx;
                dout.operand_number = opc;
                if (fin)
                begin
                    if (tag == 8'd1)
                    begin
                        brem_next = {16'd0, shifted[15:0]};
                        if (shifted[15:0] == 16'd0)
                        begin
                            opc_next = '0;
                            pidx_next = pool_n[15:0];
                            phase_next = (pool_n >= {1'b0, pcnt}) ? S_ACCESS : S_POOL_TAG;
                        end
                        else
                            phase_next = S_UTF8;
                    end
                    else if (opc < tag_operands(tag))
                        opc_next = opc + 2'd1;
                    else
                    begin
                        opc_next = '0;
                        pidx_next = pool_n[15:0];
                        phase_next = (pool_n >= {1'b0, pcnt}) ? S_ACCESS : S_POOL_TAG;
                    end
                end
            end
            S_UTF8:
            begin
                dout.entry_index = pidx;
                dout.operand_number = 2'd2;
                dout.value = {56'd0, b};
                brem_next = brem_dec;
                if (brem_dec == 32'd0)
                begin
                    opc_next = '0;
                    pidx_next = pool_n[15:0];
                    phase_next = (pool_n >= {1'b0, pcnt}) ? S_ACCESS : S_POOL_TAG;
                end
            end
            S_IFACE_COUNT:
                if (fin)
                begin
                    icnt_next = shifted[15:0];
                    iidx_next = '0;
                    phase_next = (shifted[15:0] == 16'd0) ? S_FIELDS_COUNT : S_IFACE;
                end
            S_IFACE:
            begin
                dout.entry_index = iidx;
                if (fin)
                begin
                    iidx_next = inext;
                    if (inext == icnt) phase_next = S_FIELDS_COUNT;
                end
            end
            S_FIELDS_COUNT, S_METHODS_COUNT:
                if (fin)
                begin
                    icnt_next = shifted[15:0];
                    iidx_next = '0;
                    msec_next = (ph == S_METHODS_COUNT);
                    if (shifted[15:0] != 16'd0) phase_next = S_MFLAGS;
                    else phase_next = (ph == S_METHODS_COUNT) ? S_TRAILING : S_METHODS_COUNT;
                end
            S_MFLAGS, S_MNAME, S_MDESC:
            begin
                dout.entry_index = iidx;
                dout.in_method = msec;
                if (fin)
                begin
                    if (ph == S_MFLAGS && !msec)
                    begin
                        if (shifted[STATIC_BIT_POS])
                        begin
                            dout.field_is_static = 1'b1;
                            dout.field_slot = sslot;
                            sslot_next = sslot + 16'd1;
                        end
                        else
                        begin
                            dout.field_slot = islot;
                            islot_next = islot + 16'd1;
                        end
                    end
                    phase_next = (ph == S_MFLAGS) ? S_MNAME :
                                 (ph == S_MNAME) ? S_MDESC : S_MATTRC;
                end
            end
            S_MATTRC:
            begin
                dout.entry_index = iidx;
                dout.in_method = msec;
                if (fin)
                begin
                    acnt_next = shifted[15:0];
                    aidx_next = '0;
                    if (shifted[15:0] == 16'd0)
                    begin
                        iidx_next = inext;
                        if (inext == icnt) phase_next = msec ? S_TRAILING : S_METHODS_COUNT;
                        else phase_next = S_MFLAGS;
                    end
                    else
                        phase_next = S_ANAME;
                end
            end
            S_ANAME:
            begin
                dout.entry_index = iidx;
                dout.in_method = msec;
                dout.attribute_index = aidx;
                if (fin) phase_next = S_ALEN;
            end
            S_ALEN, S_AINFO:
            begin
                dout.entry_index = iidx;
                dout.in_method = msec;
                dout.attribute_index = aidx;
                if (ph == S_AINFO)
                begin
                    dout.value = {56'd0, b};
                    brem_next = brem_dec;
                end
                else if (fin)
                    brem_next = shifted[31:0];
                if ((ph == S_AINFO && brem_dec == 32'd0) ||
                    (ph == S_ALEN && fin && shifted[31:0] == 32'd0))
                begin
                    aidx_next = anext;
                    if (anext == acnt)
                    begin
                        iidx_next = inext;
                        if (inext == icnt) phase_next = msec ? S_TRAILING : S_METHODS_COUNT;
                        else phase_next = S_MFLAGS;
                    end
                    else
                        phase_next = S_ANAME;
                end
                else if (ph == S_ALEN && fin)
                    phase_next = S_AINFO;
            end
            default: ;
        endcase

        dout.error_code = err_next;
        dout.parse_done = (phase_next == S_TRAILING);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= S_MAGIC; bif_reg <= '0; acc_reg <= '0; pidx_reg <= 16'd1;
            pcnt_reg <= '0; tag_reg <= '0; opc_reg <= '0; iidx_reg <= '0;
            icnt_reg <= '0; aidx_reg <= '0; acnt_reg <= '0; brem_reg <= '0;
            sslot_reg <= '0; islot_reg <= '0; msec_reg <= 1'b0; err_reg <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next; bif_reg <= bif_next; acc_reg <= acc_next;
            pidx_reg <= pidx_next; pcnt_reg <= pcnt_next; tag_reg <= tag_next;
            opc_reg <= opc_next; iidx_reg <= iidx_next; icnt_reg <= icnt_next;
            aidx_reg <= aidx_next; acnt_reg <= acnt_next; brem_reg <= brem_next;
            sslot_reg <= sslot_next; islot_reg <= islot_next; msec_reg <= msec_next;
            err_reg <= err_next;
        end
    end

    // halted only with a latched error
    a_halt_err: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == S_HALTED |-> err_reg != ERR_NONE)
        else $error("halted without error");
    // byte position is zero in the byte-stream phases
    a_bif_zero_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == S_UTF8 || phase_reg == S_AINFO || phase_reg == S_TRAILING)
        |-> bif_reg == 3'd0)
        else $error("byte position left over in byte-stream phase");
    a_opc_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == S_POOL_OPERAND |-> (opc_reg == 2'd1 || opc_reg == 2'd2))
        else $error("operand number out of range");
endmodule

// ===== hdl/class_file_structure_parser.sv =====
// Class file structure parser: one byte per cycle, big-endian walk of the file.
// The result word is registered: it is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while each result word is taken; the whole step is one pass of the state logic.
// Holds the next byte while the output register is full and not taken.
// Reset (rst_n low, asynchronous) waits for the magic word; starts_file restarts too.
// Depends on cfsp_pkg, cfsp_stream_if and cfsp_core.
`timescale 1ns / 1ps
module class_file_structure_parser (
    input  logic        clk,
    input  logic        rst_n,
    cfsp_stream_if.sink   byte_stream,
    cfsp_stream_if.source result_stream
);
    import cfsp_pkg::*;

    out_word_t res_next;
    out_word_t res_reg;
    logic      valid_reg;
    logic      step;

    assign byte_stream.ready = !valid_reg || result_stream.ready;
    assign step = byte_stream.valid && byte_stream.ready;

    cfsp_core u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .din  (byte_stream.payload),
        .dout (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (byte_stream.ready)
            valid_reg <= byte_stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign result_stream.valid = valid_reg;
    assign result_stream.payload = res_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !result_stream.ready |=> valid_reg && $stable(res_reg))
        else $error("result dropped while stalled");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> valid_reg)
        else $error("accepted byte gave no result");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> byte_stream.ready)
        else $error("input stalled with empty output");
endmodule

// ===== bench/class_file_structure_parser_tb.sv =====
// Self-checking bench for the class file structure parser.
// Depends on cfsp_pkg, cfsp_stream_if and the class_file_structure_parser top level.
`timescale 1ns / 1ps
module class_file_structure_parser_tb;
    import cfsp_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cfsp_stream_if #(.payload_t(in_word_t))  in_ch ();
    cfsp_stream_if #(.payload_t(out_word_t)) out_ch ();

    class_file_structure_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (in_ch.sink),
        .result_stream (out_ch.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // parser model state
    kind_t       ph;
    logic [2:0]  bif;
    logic [63:0] acc;
    logic [15:0] pidx, pcnt, iidx, icnt, aidx_s, acnt, sslots, islots;
    logic [7:0]  ctag;
    logic [1:0]  opc, errl;
    logic [31:0] brem;
    logic        msec;

    out_word_t   parse_q[$];
    in_word_t    byte_q[$];
    int          n_fail = 0;
    int          n_words = 0;
    int          n_done_words = 0;
    int          n_err_words = 0;

    task automatic parser_reset();
        ph = K_MAGIC; bif = '0; acc = '0; pidx = 16'd1; pcnt = '0; ctag = '0; opc = '0;
        iidx = '0; icnt = '0; aidx_s = '0; acnt = '0; brem = '0; sslots = '0;
        islots = '0; msec = 1'b0; errl = ERR_NONE;
    endtask

    function automatic logic shift_in(input logic [7:0] b, input logic [3:0] sz);
        acc = (bif == 3'd0) ? {56'd0, b} : {acc[55:0], b};
        if (({1'b0, bif} + 4'd1) >= sz)
        begin
            bif = 3'd0;
            return 1'b1;
        end
        bif = bif + 3'd1;
        return 1'b0;
    endfunction

    task automatic close_pool_entry();
        logic [16:0] n;
        n = {1'b0, pidx} + ((ctag == 8'd5 || ctag == 8'd6) ? 17'd2 : 17'd1);
        opc = '0;
        pidx = n[15:0];
        ph = (n >= {1'b0, pcnt}) ? K_ACCESS : K_POOL_TAG;
    endtask

    task automatic close_member();
        iidx = iidx + 16'd1;
        if (iidx == icnt)
            ph = msec ? K_TRAILING : K_METHODS_COUNT;
        else
            ph = K_MFLAGS;
    endtask

    task automatic close_attribute();
        aidx_s = aidx_s + 16'd1;
        if (aidx_s == acnt)
            close_member();
        else
            ph = K_ANAME;
    endtask

    task automatic parse_byte(input in_word_t w, output out_word_t r);
        logic [7:0] b;
        logic       c;
        logic [3:0] osz;
        b = w.byte_value;
        c = 1'b0;
        r = '0;
        if (w.starts_file)
            parser_reset();
        r.element_kind = ph;
        case (ph)
            K_HALTED: ;
            K_TRAILING: r.value = {56'd0, b};
            K_MAGIC:
            begin
                c = shift_in(b, 4'd4);
                if (c)
                begin
                    if (acc[31:0] != MAGIC_WORD)
                    begin
                        errl = ERR_MAGIC;
                        ph = K_HALTED;
                    end
                    else
                        ph = K_MINOR;
                end
            end
            K_MINOR, K_ACCESS, K_THIS, K_SUPER:
            begin
                c = shift_in(b, 4'd2);
                if (c)
                    ph = kind_t'(ph + 5'd1);
            end
            K_MAJOR:
            begin
                c = shift_in(b, 4'd2);
                if (c)
                    ph = K_POOL_COUNT;
            end
            K_POOL_COUNT:
            begin
                c = shift_in(b, 4'd2);
                if (c)
                begin
                    pcnt = acc[15:0];
                    pidx = 16'd1;
                    ph = (pcnt <= 16'd1) ? K_ACCESS : K_POOL_TAG;
                end
            end
            K_POOL_TAG:
            begin
                r.entry_index = pidx;
                c = shift_in(b, 4'd1);
                ctag = b;
                if (!((b == 8'd1) || (b >= 8'd3 && b <= 8'd12) || b == 8'd15 ||
                      b == 8'd16 || b == 8'd18))
                begin
                    errl = ERR_TAG;
                    ph = K_HALTED;
                end
                else
                begin
                    opc = 2'd1;
                    ph = K_POOL_OPERAND;
                end
            end
            K_POOL_OPERAND:
            begin
                r.entry_index = pidx;
                r.operand_number = opc;
                if (ctag == 8'd15)
                    osz = (opc == 2'd1) ? 4'd1 : 4'd2;
                else if (ctag == 8'd3 || ctag == 8'd4)
                    osz = 4'd4;
                else if (ctag == 8'd5 || ctag == 8'd6)
                    osz = 4'd8;
                else
                    osz = 4'd2;
                c = shift_in(b, osz);
                if (c)
                begin
                    if (ctag == 8'd1)
                    begin
                        brem = {16'd0, acc[15:0]};
                        if (brem == 32'd0)
                            close_pool_entry();
                        else
                            ph = K_UTF8;
                    end
                    else if (opc < (((ctag >= 8'd9 && ctag <= 8'd12) || ctag == 8'd15 ||
                                     ctag == 8'd18) ? 2'd2 : 2'd1))
                        opc = opc + 2'd1;
                    else
                        close_pool_entry();
                end
            end
            K_UTF8:
            begin
                r.entry_index = pidx;
                r.operand_number = 2'd2;
                r.value = {56'd0, b};
                brem = brem - 32'd1;
                if (brem == 32'd0)
                    close_pool_entry();
            end
            K_IFACE_COUNT:
            begin
                c = shift_in(b, 4'd2);
                if (c)
                begin
                    icnt = acc[15:0];
                    iidx = '0;
                    ph = (icnt == 16'd0) ? K_FIELDS_COUNT : K_IFACE;
                end
            end
            K_IFACE:
            begin
                r.entry_index = iidx;
                c = shift_in(b, 4'd2);
                if (c)
                begin
                    iidx = iidx + 16'd1;
                    if (iidx == icnt)
                        ph = K_FIELDS_COUNT;
                end
            end
            K_FIELDS_COUNT, K_METHODS_COUNT:
            begin
                c = shift_in(b, 4'd2);
                if (c)
                begin
                    icnt = acc[15:0];
                    iidx = '0;
                    msec = (ph == K_METHODS_COUNT);
                    if (icnt != 16'd0)
                        ph = K_MFLAGS;
                    else
                        ph = msec ? K_TRAILING : K_METHODS_COUNT;
                end
            end
            K_MFLAGS, K_MNAME, K_MDESC:
            begin
                r.entry_index = iidx;
                r.in_method = msec;
                c = shift_in(b, 4'd2);
                if (c)
                begin
                    if (ph == K_MFLAGS && !msec)
                    begin
                        if (acc[STATIC_BIT_POS])
                        begin
                            r.field_is_static = 1'b1;
                            r.field_slot = sslots;
                            sslots = sslots + 16'd1;
                        end
                        else
                        begin
                            r.field_slot = islots;
                            islots = islots + 16'd1;
                        end
                    end
                    ph = kind_t'(ph + 5'd1);
                end
            end
            K_MATTRC:
            begin
                r.entry_index = iidx;
                r.in_method = msec;
                c = shift_in(b, 4'd2);
                if (c)
                begin
                    acnt = acc[15:0];
                    aidx_s = '0;
                    if (acnt == 16'd0)
                        close_member();
                    else
                        ph = K_ANAME;
                end
            end
            K_ANAME, K_ALEN:
            begin
                r.entry_index = iidx;
                r.in_method = msec;
                r.attribute_index = aidx_s;
                c = shift_in(b, (ph == K_ANAME) ? 4'd2 : 4'd4);
                if (c)
                begin
                    if (ph == K_ANAME)
                        ph = K_ALEN;
                    else
                    begin
                        brem = acc[31:0];
                        if (brem == 32'd0)
                            close_attribute();
                        else
                            ph = K_AINFO;
                    end
                end
            end
            default:
            begin
                r.entry_index = iidx;
                r.in_method = msec;
                r.attribute_index = aidx_s;
                r.value = {56'd0, b};
                brem = brem - 32'd1;
                if (brem == 32'd0)
                    close_attribute();
            end
        endcase
        if (c)
            r.value = acc;
        r.value_complete = c;
        r.error_code = errl;
        r.parse_done = (ph == K_TRAILING);
    endtask

    // stimulus builders
    task automatic put(input logic [7:0] b, input logic s = 1'b0);
        in_word_t w;
        w.byte_value = b;
        w.starts_file = s;
        byte_q.insert(byte_q.size(), w);
    endtask

    task automatic put16(input logic [15:0] v);
        put(v[15:8]);
        put(v[7:0]);
    endtask

    task automatic put_bytes(input int n);
        for (int i = 0; i < n; i++)
            put(8'($urandom_range(0, 255)));
    endtask

    // one well-formed class file with random content, small sizes
    task automatic build_class();
        int np, t, nl, nm, na, al;
        put(8'hCA, 1'b1); put(8'hFE); put(8'hBA); put(8'hBE);
        put16(16'($urandom)); put16(16'($urandom));
        np = int'($urandom_range(0, 7));
        put16(16'(np));
        for (int i = 1; i < np; i++)
        begin
            case ($urandom_range(0, 13))
                0: t = 1;  1: t = 3;  2: t = 4;  3: t = 5;  4: t = 6;  5: t = 7;
                6: t = 8;  7: t = 9;  8: t = 10; 9: t = 11; 10: t = 12; 11: t = 15;
                12: t = 16; default: t = 18;
            endcase
            put(8'(t));
            case (t)
                1:
                begin
                    nl = int'($urandom_range(0, 4));
                    put16(16'(nl));
                    put_bytes(nl);
                end
                3, 4: put_bytes(4);
                5, 6:
                begin
                    put_bytes(8);
                    i++;
                end
                7, 8, 16: put_bytes(2);
                15: put_bytes(3);
                default: put_bytes(4);
            endcase
        end
        put_bytes(6);
        nl = int'($urandom_range(0, 2));
        put16(16'(nl));
        put_bytes(2 * nl);
        for (int s = 0; s < 2; s++)
        begin
            nm = int'($urandom_range(0, 3));
            put16(16'(nm));
            for (int m = 0; m < nm; m++)
            begin
                put16(16'($urandom));
                put_bytes(4);
                na = int'($urandom_range(0, 2));
                put16(16'(na));
                for (int a = 0; a < na; a++)
                begin
                    put_bytes(2);
                    al = int'($urandom_range(0, 3));
                    put(8'd0); put(8'd0); put(8'd0); put(8'(al));
                    put_bytes(al);
                end
            end
        end
        put_bytes(int'($urandom_range(0, 3)));
    endtask

    // directed rows: byte, start, check-expected flag, expected kind/err/value
    typedef struct {
        logic [7:0]  b;
        logic        s;
        logic        fixed;
        kind_t       kind;
        logic [1:0]  err;
        logic [63:0] val;
    } row_t;

    row_t rows [0:24] = '{
        '{8'h00, 1'b0, 1'b1, K_MAGIC,  ERR_NONE,  64'h00},
        '{8'hFF, 1'b0, 1'b1, K_MAGIC,  ERR_NONE,  64'h00},
        '{8'h00, 1'b0, 1'b0, K_MAGIC,  ERR_NONE,  64'h0},
        '{8'hFF, 1'b0, 1'b1, K_MAGIC,  ERR_MAGIC, 64'hFF00FF},
        '{8'hAB, 1'b0, 1'b1, K_HALTED, ERR_MAGIC, 64'h0},
        '{8'hCA, 1'b1, 1'b0, K_MAGIC,  ERR_NONE,  64'h0},
        '{8'hFE, 1'b0, 1'b0, K_MAGIC,  ERR_NONE,  64'h0},
        '{8'hBA, 1'b0, 1'b0, K_MAGIC,  ERR_NONE,  64'h0},
        '{8'hBE, 1'b0, 1'b1, K_MAGIC,  ERR_NONE,  64'hCAFEBABE},
        '{8'hFF, 1'b0, 1'b0, K_MINOR,  ERR_NONE,  64'h0},
        '{8'hFF, 1'b0, 1'b1, K_MINOR,  ERR_NONE,  64'hFFFF},
        '{8'h00, 1'b0, 1'b0, K_MAJOR,  ERR_NONE,  64'h0},
        '{8'h00, 1'b0, 1'b0, K_MAJOR,  ERR_NONE,  64'h0},
        '{8'h00, 1'b0, 1'b0, K_POOL_COUNT, ERR_NONE, 64'h0},
        '{8'h03, 1'b0, 1'b0, K_POOL_COUNT, ERR_NONE, 64'h0},
        '{8'h05, 1'b0, 1'b0, K_POOL_TAG, ERR_NONE, 64'h0},
        '{8'h01, 1'b0, 1'b0, K_POOL_OPERAND, ERR_NONE, 64'h0},
        '{8'h23, 1'b0, 1'b0, K_POOL_OPERAND, ERR_NONE, 64'h0},
        '{8'h45, 1'b0, 1'b0, K_POOL_OPERAND, ERR_NONE, 64'h0},
        '{8'h67, 1'b0, 1'b0, K_POOL_OPERAND, ERR_NONE, 64'h0},
        '{8'h89, 1'b0, 1'b0, K_POOL_OPERAND, ERR_NONE, 64'h0},
        '{8'hAB, 1'b0, 1'b0, K_POOL_OPERAND, ERR_NONE, 64'h0},
        '{8'hCD, 1'b0, 1'b0, K_POOL_OPERAND, ERR_NONE, 64'h0},
        '{8'hEF, 1'b0, 1'b0, K_POOL_OPERAND, ERR_NONE, 64'h0},
        '{8'h00, 1'b0, 1'b0, K_ACCESS, ERR_NONE, 64'h0}
    };

    // check results
    task automatic check_word(input out_word_t got);
        out_word_t e;
        if (parse_q.size() == 0)
        begin
            $error("unexpected result word kind=%0d", got.element_kind);
            n_fail++;
            return;
        end
        e = parse_q[0];
        parse_q.delete(0);
        n_words++;
        if (got.parse_done)
            n_done_words++;
        if (got.error_code != ERR_NONE)
            n_err_words++;
        if (got.element_kind != e.element_kind)
        begin
            $error("element_kind exp %0d got %0d", e.element_kind, got.element_kind);
            n_fail++;
        end
        if (got.in_method != e.in_method)
        begin
            $error("in_method exp %0d got %0d", e.in_method, got.in_method);
            n_fail++;
        end
        if (got.entry_index != e.entry_index)
        begin
            $error("entry_index exp %0d got %0d", e.entry_index, got.entry_index);
            n_fail++;
        end
        if (got.attribute_index != e.attribute_index)
        begin
            $error("attribute_index exp %0d got %0d", e.attribute_index, got.attribute_index);
            n_fail++;
        end
        if (got.operand_number != e.operand_number)
        begin
            $error("operand_number exp %0d got %0d", e.operand_number, got.operand_number);
            n_fail++;
        end
        if (got.value !== e.value)
        begin
            $error("value exp %h got %h", e.value, got.value);
            n_fail++;
        end
        if (got.value_complete != e.value_complete)
        begin
            $error("value_complete exp %0d got %0d", e.value_complete, got.value_complete);
            n_fail++;
        end
        if (got.field_is_static != e.field_is_static)
        begin
            $error("field_is_static exp %0d got %0d", e.field_is_static, got.field_is_static);
            n_fail++;
        end
        if (got.field_slot != e.field_slot)
        begin
            $error("field_slot exp %0d got %0d", e.field_slot, got.field_slot);
            n_fail++;
        end
        if (got.error_code != e.error_code)
        begin
            $error("error_code exp %0d got %0d", e.error_code, got.error_code);
            n_fail++;
        end
        if (got.parse_done != e.parse_done)
        begin
            $error("parse_done exp %0d got %0d", e.parse_done, got.parse_done);
            n_fail++;
        end
    endtask

    // sink side: random stall per word
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13));
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk iff out_ch.valid);
            check_word(out_ch.payload);
        end
    end

    // send one word, predicting its result on acceptance; valid stays up afterwards
    task automatic send_word(input in_word_t w, input int gap);
        out_word_t r;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= w;
        @(posedge clk iff in_ch.ready);
        parse_byte(w, r);
        parse_q.insert(parse_q.size(), r);
    endtask

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 13));
    endfunction

    initial
    begin
        in_word_t  w;
        out_word_t r;
        bit        burst;
        int        n_items;
        in_ch.valid <= 1'b0;
        in_ch.payload <= '0;
        parser_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            w.byte_value = rows[i].b;
            w.starts_file = rows[i].s;
            send_word(w, draw_gap(1'b0));
            r = parse_q[$];
            if (rows[i].fixed && (r.element_kind != rows[i].kind ||
                r.error_code != rows[i].err || r.value != rows[i].val))
            begin
                $error("directed row %0d: kind exp %0d got %0d, error_code exp %0d got %0d, value exp %h got %h",
                       i, rows[i].kind, r.element_kind, rows[i].err, r.error_code,
                       rows[i].val, r.value);
                n_fail++;
            end
        end

        // unknown tag halts the parse
        put(8'hCA, 1'b1); put(8'hFE); put(8'hBA); put(8'hBE);
        put16(16'd0); put16(16'd0); put16(16'h0005); put(8'h02); put(8'h11);
        // pool count two; a double in the last slot ends the pool
        build_class();
        put(8'hCA, 1'b1); put(8'hFE); put(8'hBA); put(8'hBE);
        put16(16'd0); put16(16'd0); put16(16'd2); put(8'h06); put_bytes(8);
        put16(16'hFFFF); put_bytes(4); put16(16'd0); put16(16'd2);
        put16(16'h0008); put_bytes(4); put16(16'd0);
        put16(16'hFFF7); put_bytes(4); put16(16'd0);
        put16(16'd0); put_bytes(3);

        n_items = 0;
        burst = 1'b0;
        while (n_items < 550 || byte_q.size() != 0)
        begin
            if (byte_q.size() == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    build_class();
                if ($urandom_range(0, 7) == 0)
                    burst = ~burst;
            end
            w = byte_q[0];
            byte_q.delete(0);
            // corrupt an occasional byte to reach the error paths
            if ($urandom_range(0, 199) == 0)
                w.byte_value = 8'($urandom_range(0, 255));
            if (n_items == 300)
            begin
                // drain everything in flight before going on
                in_ch.valid <= 1'b0;
                wait (parse_q.size() == 0);
                @(posedge clk);
            end
            send_word(w, draw_gap(burst));
            n_items++;
        end

        in_ch.valid <= 1'b0;
        wait (parse_q.size() == 0);
        repeat (20) @(posedge clk);
        $display("Checked %0d result words over directed rows and random class files;",
                 n_words);
        $display("%0d words after the methods, %0d words with an error latched.",
                 n_done_words, n_err_words);
        if (n_fail == 0 && parse_q.size() == 0)
            $display("class_file_structure_parser_tb: PASS");
        else
            $display("class_file_structure_parser_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("class_file_structure_parser_tb: FAIL");
        $finish;
    end
endmodule
